// ===== src/drtc_pkg.sv =====
// drtc_pkg: constants, codes and double precision helper functions
// for the double round and type convert core; no dependencies
package drtc_pkg;

  localparam logic [63:0] SIGN_BIT       = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MINUS_ONE_BITS = 64'hbff0_0000_0000_0000;
  localparam logic [10:0] EXP_ALL        = 11'h7ff;

  localparam logic [2:0] MODE_PASS  = 3'd0;
  localparam logic [2:0] MODE_ROUND = 3'd1;
  localparam logic [2:0] MODE_FLOOR = 3'd2;
  localparam logic [2:0] MODE_CEIL  = 3'd3;
  localparam logic [2:0] MODE_ABS   = 3'd4;

  localparam logic [3:0] TT_BOOL   = 4'd0;
  localparam logic [3:0] TT_DOUBLE = 4'd1;
  localparam logic [3:0] TT_SINGLE = 4'd2;
  localparam logic [3:0] TT_U8     = 4'd3;
  localparam logic [3:0] TT_S8     = 4'd4;
  localparam logic [3:0] TT_U16    = 4'd5;
  localparam logic [3:0] TT_S16    = 4'd6;
  localparam logic [3:0] TT_U32    = 4'd7;
  localparam logic [3:0] TT_S32    = 4'd8;
  localparam logic [3:0] TT_U64    = 4'd9;
  localparam logic [3:0] TT_S64    = 4'd10;

  localparam logic [7:0] REG_CONVERT_MODE = 8'd0;
  localparam logic [7:0] REG_TARGET_TYPE  = 8'd1;

  // add one unit at bit fb of the significand, carry bumps the exponent
  function automatic logic [63:0] mag_up(input logic [63:0] b, input logic [5:0] fb);
    logic [53:0] m;
    logic [63:0] r;
    begin
      m = {2'b01, b[51:0]} + (54'd1 << fb);
      if (m[53]) begin
        r = {b[63], b[62:52] + 11'd1, 52'd0};
      end else begin
        r = {b[63:52], m[51:0]};
      end
      return r;
    end
  endfunction

  function automatic logic [63:0] floor_fn(input logic [63:0] b);
    logic [10:0] ex;
    logic [5:0]  fb;
    logic [63:0] mask;
    logic [63:0] t;
    logic [63:0] r;
    begin
      ex   = b[62:52];
      fb   = 6'(11'd1075 - ex);
      mask = (64'd1 << fb) - 64'd1;
      t    = b & ~mask;
      if (ex == EXP_ALL || ex >= 11'd1075) begin
        r = b;
      end else if (ex < 11'd1023) begin
        if (b[62:0] == 63'd0) r = b;
        else r = b[63] ? MINUS_ONE_BITS : 64'd0;
      end else if ((b & mask) == 64'd0) begin
        r = b;
      end else if (!b[63]) begin
        r = t;
      end else begin
        r = mag_up(t, fb);
      end
      return r;
    end
  endfunction

  // floor(x + 0.5) with the sum rounded to double first
  function automatic logic [63:0] round_fn(input logic [63:0] b);
    logic [10:0] ex;
    logic [5:0]  hs;
    logic [5:0]  fb;
    logic [53:0] s;
    logic [53:0] rr;
    logic [63:0] fl;
    logic [63:0] mask;
    logic [63:0] t;
    logic [63:0] r;
    begin
      ex   = b[62:52];
      hs   = 6'(11'd1074 - ex);
      fb   = 6'(11'd1075 - ex);
      s    = {2'b01, b[51:0]} + (54'd1 << hs);
      rr   = {1'b0, s[53:1]} + {53'd0, s[0] & s[1]};
      mask = (64'd1 << fb) - 64'd1;
      t    = b & ~mask;
      if (s[53]) begin
        if (rr[53]) fl = {1'b0, ex + 11'd2, 52'd0};
        else fl = {1'b0, ex + 11'd1, rr[51:0]};
      end else begin
        fl = {1'b0, ex, s[51:0]};
      end
      if (ex == EXP_ALL || ex > 11'd1075) begin
        r = b;
      end else if (!b[63]) begin
        if (ex < 11'd1021) r = 64'd0;
        else if (ex == 11'd1075) r = b[0] ? mag_up(b, 6'd0) : b;
        else r = floor_fn(fl);
      end else begin
        if (ex < 11'd1022) r = 64'd0;
        else if (ex == 11'd1022) r = (b[51:0] != 52'd0) ? MINUS_ONE_BITS : 64'd0;
        else if (ex == 11'd1075) r = {b[63:1], 1'b0};
        else if ((b & mask) > (64'd1 << (fb - 6'd1))) r = mag_up(t, fb);
        else r = t;
      end
      return r;
    end
  endfunction

  function automatic logic [31:0] single_fn(input logic [63:0] b);
    logic [10:0] ex;
    logic [10:0] k;
    logic [5:0]  sh;
    logic [63:0] m;
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] half;
    logic [31:0] r;
    logic [31:0] res;
    begin
      ex   = b[62:52];
      k    = 11'd926 - ex;
      m    = {11'd0, 1'b1, b[51:0]};
      if (ex >= 11'd897) sh = 6'd29;
      else if (k > 11'd60) sh = 6'd60;
      else sh = k[5:0];
      q    = m >> sh;
      rem  = m & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 6'd1);
      if (rem > half || (rem == half && q[0])) q = q + 64'd1;
      if (ex >= 11'd897) r = {1'b0, 8'(ex - 11'd897), 23'd0} + q[31:0];
      else r = q[31:0];
      if (r > 32'h7f80_0000) r = 32'h7f80_0000;
      if (ex == EXP_ALL) begin
        if (b[51:0] == 52'd0) res = {b[63], 31'h7f80_0000};
        else res = {b[63], 31'h7fc0_0000 | {8'd0, b[51:29]}};
      end else if (ex == 11'd0) begin
        res = {b[63], 31'd0};
      end else if (ex >= 11'd1151) begin
        res = {b[63], 31'h7f80_0000};
      end else begin
        res = {b[63], r[30:0]};
      end
      return res;
    end
  endfunction

  // returns {flag, value}
  function automatic logic [64:0] int_fn(input logic [63:0] b, input logic [3:0] tt);
    logic [10:0] ex;
    logic [5:0]  e;
    logic [63:0] m;
    logic [63:0] wmask;
    logic [63:0] pmax;
    logic [63:0] nmax;
    logic [63:0] mag;
    logic        sgn;
    logic        big;
    logic        flag;
    logic [63:0] v;
    begin
      ex = b[62:52];
      e  = 6'(ex - 11'd1023);
      m  = {11'd0, 1'b1, b[51:0]};
      case (tt)
        TT_U8, TT_S8:   wmask = 64'hff;
        TT_U16, TT_S16: wmask = 64'hffff;
        TT_U32, TT_S32: wmask = 64'hffff_ffff;
        default:        wmask = '1;
      endcase
      sgn  = (tt == TT_S8 || tt == TT_S16 || tt == TT_S32 || tt == TT_S64);
      pmax = sgn ? (wmask >> 1) : wmask;
      nmax = sgn ? (pmax + 64'd1) : 64'd0;
      big  = (ex >= 11'd1087);
      mag  = 64'd0;
      flag = 1'b0;
      if (ex >= 11'd1023 && ex < 11'd1087) begin
        if (e >= 6'd52) mag = m << (e - 6'd52);
        else mag = m >> (6'd52 - e);
      end
      if (ex == EXP_ALL && b[51:0] != 52'd0) begin
        flag = 1'b1;
        v    = 64'd0;
      end else if (!b[63]) begin
        if (big || mag > pmax) begin
          flag = 1'b1;
          mag  = pmax;
        end
        v = mag & wmask;
      end else begin
        if (big || mag > nmax) begin
          flag = 1'b1;
          mag  = nmax;
        end
        v = (64'd0 - mag) & wmask;
      end
      return {flag, v};
    end
  endfunction

endpackage

// ===== src/drtc_op.sv =====
// drtc_op: applies the configured operation (round, floor, ceil, abs or pass) to one double
// depends on drtc_pkg
module drtc_op
  import drtc_pkg::*;
(
  input  logic [2:0]  mode,
  input  logic [63:0] bits_in,
  output logic [63:0] bits_out
);

  always_comb begin
    case (mode)
      MODE_ROUND: bits_out = round_fn(bits_in);
      MODE_FLOOR: bits_out = floor_fn(bits_in);
      MODE_CEIL:  bits_out = floor_fn(bits_in ^ SIGN_BIT) ^ SIGN_BIT;
      MODE_ABS:   bits_out = bits_in & ~SIGN_BIT;
      default:    bits_out = bits_in;
    endcase
  end

endmodule

// ===== src/drtc_conv.sv =====
// drtc_conv: converts a double to the configured target type and byte count
// depends on drtc_pkg
module drtc_conv
  import drtc_pkg::*;
(
  input  logic [3:0]  tt,
  input  logic [63:0] bits_in,
  output logic [63:0] result_bits,
  output logic [3:0]  result_bytes,
  output logic        out_of_range
);

  logic [64:0] int_res;

  assign int_res = int_fn(bits_in, tt);

  always_comb begin
    out_of_range = 1'b0;
    case (tt)
      TT_BOOL: begin
        result_bits  = {63'd0, bits_in[62:0] != 63'd0};
        result_bytes = 4'd1;
      end
      TT_SINGLE: begin
        result_bits  = {32'd0, single_fn(bits_in)};
        result_bytes = 4'd4;
      end
      TT_U8, TT_S8, TT_U16, TT_S16, TT_U32, TT_S32, TT_U64, TT_S64: begin
        result_bits  = int_res[63:0];
        out_of_range = int_res[64];
        case (tt)
          TT_U8, TT_S8:   result_bytes = 4'd1;
          TT_U16, TT_S16: result_bytes = 4'd2;
          TT_U32, TT_S32: result_bytes = 4'd4;
          default:        result_bytes = 4'd8;
        endcase
      end
      default: begin
        result_bits  = bits_in;
        result_bytes = 4'd8;
      end
    endcase
  end

endmodule

// ===== src/double_round_and_type_convert_core.sv =====
// double_round_and_type_convert_core: top level, config registers and pipeline
// depends on drtc_pkg, drtc_op, drtc_conv
//
// channel   direction  handshake              payload
// in_       input      start & !busy          in_value_bits
// out_      output     out_strobe             out_result_bits, out_result_bytes,
//                                             out_out_of_range
// cfg_      input      cfg_valid & cfg_ready  cfg_index, cfg_data
//
// one item per cycle; the result is strobed as it leaves the result register
// stages: input register, operation register, result register
// busy and cfg_ready stay at their idle values, so nothing stalls
// rst_n clears the valid flags and sets convert_mode 0, target_type 1
module double_round_and_type_convert_core
  import drtc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_value_bits,
  output logic        out_strobe,
  output logic [63:0] out_result_bits,
  output logic [3:0]  out_result_bytes,
  output logic        out_out_of_range,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  logic [2:0]  mode_r;
  logic [3:0]  type_r;
  logic        in_vld_r;
  logic [63:0] in_bits_r;
  logic        mid_vld_r;
  logic [63:0] mid_bits_r;
  logic [63:0] op_bits;
  logic [63:0] conv_bits;
  logic [3:0]  conv_bytes;
  logic        conv_oor;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_PASS;
      type_r <= TT_DOUBLE;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_CONVERT_MODE) mode_r <= cfg_data[2:0];
      if (cfg_index == REG_TARGET_TYPE) type_r <= cfg_data[3:0];
    end
  end

  drtc_op u_op (
    .mode     (mode_r),
    .bits_in  (in_bits_r),
    .bits_out (op_bits)
  );

  drtc_conv u_conv (
    .tt           (type_r),
    .bits_in      (mid_bits_r),
    .result_bits  (conv_bits),
    .result_bytes (conv_bytes),
    .out_of_range (conv_oor)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r   <= 1'b0;
      mid_vld_r  <= 1'b0;
      out_strobe <= 1'b0;
    end else begin
      in_vld_r   <= start && !busy;
      mid_vld_r  <= in_vld_r;
      out_strobe <= mid_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    in_bits_r        <= in_value_bits;
    mid_bits_r       <= op_bits;
    out_result_bits  <= conv_bits;
    out_result_bytes <= conv_bytes;
    out_out_of_range <= conv_oor;
  end

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_strobe)
    else $error("item result missing after three cycles");

  a_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_result_bytes == 4'd1 || out_result_bytes == 4'd2 ||
                    out_result_bytes == 4'd4 || out_result_bytes == 4'd8))
    else $error("bad byte count");

  a_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_result_bytes == 4'd1) |-> out_result_bits[63:8] == 56'd0)
    else $error("bytes above count not zero");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(mid_vld_r))
    else $error("result without item");
`endif

endmodule

// ===== verif/drtc_checker.sv =====
// drtc_checker: watches the input, result and config channels of the convert core,
// predicts each result from its own copy of the registers and compares
// depends on drtc_pkg
`timescale 1ns / 1ps
module drtc_checker
  import drtc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [63:0] in_value_bits,
  input  logic        out_strobe,
  input  logic [63:0] out_result_bits,
  input  logic [3:0]  out_result_bytes,
  input  logic        out_out_of_range,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [63:0] bits;
    logic [3:0]  nbytes;
    logic        oor;
  } conv_result_t;

  conv_result_t result_q[$];
  logic [2:0] mode_reg;
  logic [3:0] type_reg;

  function automatic logic [63:0] floor_dbl(input logic [63:0] b);
    logic [10:0] ex;
    logic [63:0] mask;
    logic [63:0] t;
    begin
      ex = b[62:52];
      if (ex == EXP_ALL || ex >= 11'd1075) return b;
      if (ex < 11'd1023) begin
        if (b[62:0] == 63'd0) return b;
        return b[63] ? MINUS_ONE_BITS : 64'd0;
      end
      mask = (64'd1 << (11'd1075 - ex)) - 64'd1;
      if ((b & mask) == 64'd0) return b;
      t = b & ~mask;
      if (!b[63]) return t;
      return $realtobits($bitstoreal(t) - 1.0);
    end
  endfunction

  function automatic logic [31:0] dbl_to_single(input logic [63:0] b);
    logic [10:0] ex;
    logic [63:0] m;
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] half;
    int          fe;
    int          sh;
    logic [31:0] r;
    begin
      ex = b[62:52];
      if (ex == EXP_ALL) begin
        if (b[51:0] == 52'd0) return {b[63], 8'hff, 23'd0};
        return {b[63], 31'h7fc0_0000} | {9'd0, b[51:29]};
      end
      if (ex == 11'd0) return {b[63], 31'd0};
      m  = {11'd0, 1'b1, b[51:0]};
      fe = int'(ex) - 1023 + 127;
      if (fe >= 255) return {b[63], 8'hff, 23'd0};
      if (fe >= 1) sh = 29;
      else sh = (30 - fe > 60) ? 60 : 30 - fe;
      q    = m >> sh;
      rem  = m & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && q[0])) q = q + 64'd1;
      if (fe >= 1) r = (32'(fe - 1) << 23) + q[31:0];
      else r = q[31:0];
      if (r > 32'h7f80_0000) r = 32'h7f80_0000;
      return {b[63], 31'd0} | r;
    end
  endfunction

  function automatic logic [64:0] dbl_to_int(input logic [63:0] b, input int nbits,
                                              input logic sgn);
    logic [10:0] ex;
    logic [63:0] m;
    logic [63:0] wmask;
    logic [63:0] pmax;
    logic [63:0] nmax;
    logic [63:0] mag;
    logic        big;
    int          e;
    begin
      ex    = b[62:52];
      wmask = (nbits >= 64) ? '1 : ((64'd1 << nbits) - 64'd1);
      pmax  = sgn ? (wmask >> 1) : wmask;
      nmax  = sgn ? (pmax + 64'd1) : 64'd0;
      mag   = 64'd0;
      big   = 1'b0;
      if (ex == EXP_ALL) begin
        if (b[51:0] != 52'd0) return {1'b1, 64'd0};
        big = 1'b1;
      end else if (ex >= 11'd1087) begin
        big = 1'b1;
      end else if (ex >= 11'd1023) begin
        m   = {11'd0, 1'b1, b[51:0]};
        e   = int'(ex) - 1023;
        mag = (e >= 52) ? (m << (e - 52)) : (m >> (52 - e));
      end
      if (!b[63]) begin
        if (big || mag > pmax) return {1'b1, pmax & wmask};
        return {1'b0, mag & wmask};
      end
      if (big || mag > nmax) return {1'b1, (64'd0 - nmax) & wmask};
      return {1'b0, (64'd0 - mag) & wmask};
    end
  endfunction

  function automatic conv_result_t convert_sample(input logic [63:0] v, input logic [2:0] md,
                                                   input logic [3:0] tt);
    logic [63:0]  b;
    logic [64:0]  iv;
    conv_result_t r;
    begin
      b = v;
      case (md)
        MODE_ROUND: if (b[62:52] != EXP_ALL) b = floor_dbl($realtobits($bitstoreal(b) + 0.5));
        MODE_FLOOR: b = floor_dbl(b);
        MODE_CEIL:  b = floor_dbl(b ^ SIGN_BIT) ^ SIGN_BIT;
        MODE_ABS:   b = b & ~SIGN_BIT;
        default: ;
      endcase
      r.oor = 1'b0;
      case (tt)
        TT_BOOL: begin
          r.bits = {63'd0, b[62:0] != 63'd0};
          r.nbytes = 4'd1;
        end
        TT_SINGLE: begin
          r.bits = {32'd0, dbl_to_single(b)};
          r.nbytes = 4'd4;
        end
        TT_U8, TT_S8: begin
          iv = dbl_to_int(b, 8, tt == TT_S8);
          {r.oor, r.bits} = iv;
          r.nbytes = 4'd1;
        end
        TT_U16, TT_S16: begin
          iv = dbl_to_int(b, 16, tt == TT_S16);
          {r.oor, r.bits} = iv;
          r.nbytes = 4'd2;
        end
        TT_U32, TT_S32: begin
          iv = dbl_to_int(b, 32, tt == TT_S32);
          {r.oor, r.bits} = iv;
          r.nbytes = 4'd4;
        end
        TT_U64, TT_S64: begin
          iv = dbl_to_int(b, 64, tt == TT_S64);
          {r.oor, r.bits} = iv;
          r.nbytes = 4'd8;
        end
        default: begin
          r.bits = b;
          r.nbytes = 4'd8;
        end
      endcase
      return r;
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  always @(posedge clk) begin
    conv_result_t want;
    if (!rst_n) begin
      mode_reg = MODE_PASS;
      type_reg = TT_DOUBLE;
      result_q.delete();
    end else begin
      if (out_strobe) begin
        if (result_q.size() == 0) begin
          report_mismatch("unexpected item", out_result_bits, 64'd0);
        end else begin
          want = result_q.pop_front();
          if (out_result_bits !== want.bits)
            report_mismatch("result_bits", out_result_bits, want.bits);
          if (out_result_bytes !== want.nbytes)
            report_mismatch("result_bytes", 64'(out_result_bytes), 64'(want.nbytes));
          if (out_out_of_range !== want.oor)
            report_mismatch("out_of_range", 64'(out_out_of_range), 64'(want.oor));
        end
      end
      if (start && !busy) result_q.push_back(convert_sample(in_value_bits, mode_reg, type_reg));
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_CONVERT_MODE) mode_reg = cfg_data[2:0];
        else if (cfg_index == REG_TARGET_TYPE) type_reg = cfg_data[3:0];
      end
    end
    pending = result_q.size();
  end

endmodule

// ===== verif/tb_double_round_and_type_convert_core.sv =====
// tb_double_round_and_type_convert_core: stimulus and verdict for the convert core,
// sweeps every mode and target type; depends on drtc_pkg, drtc_checker and the core
`timescale 1ns / 1ps
module tb_double_round_and_type_convert_core;
  import drtc_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [63:0] in_value_bits = 64'd0;
  logic        out_strobe;
  logic [63:0] out_result_bits;
  logic [3:0]  out_result_bytes;
  logic        out_out_of_range;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = 8'd0;
  logic [7:0]  cfg_data = 8'd0;
  int          fail_count;
  int          pending;

  logic [63:0] special_vals[25] = '{
    64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000, 64'h3ff0_0000_0000_0000,
    64'hbff0_0000_0000_0000, 64'h3fe0_0000_0000_0000, 64'hbfe0_0000_0000_0000,
    64'h3ff8_0000_0000_0000, 64'h4004_0000_0000_0000, 64'hc004_0000_0000_0000,
    64'h7ff0_0000_0000_0000, 64'hfff0_0000_0000_0000, 64'h7ff8_0000_0000_0000,
    64'hfff0_0000_0000_0001, 64'h7fef_ffff_ffff_ffff, 64'h0000_0000_0000_0001,
    64'h406f_f666_6666_6666, 64'hc060_1ccc_cccc_cccd, 64'h43e0_0000_0000_0000,
    64'hc3e0_0000_0000_0000, 64'h43f0_0000_0000_0000, 64'h3fdf_ffff_ffff_ffff,
    64'h4330_0000_0000_0001, 64'hbfd3_3333_3333_3333, 64'h47ef_ffff_efff_ffff,
    64'h380f_ffff_ffff_ffff
  };

  always #5 clk = ~clk;

  double_round_and_type_convert_core u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_value_bits(in_value_bits),
    .out_strobe(out_strobe), .out_result_bits(out_result_bits),
    .out_result_bytes(out_result_bytes), .out_out_of_range(out_out_of_range),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  drtc_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_value_bits(in_value_bits),
    .out_strobe(out_strobe), .out_result_bits(out_result_bits),
    .out_result_bytes(out_result_bytes), .out_out_of_range(out_out_of_range),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  task automatic write_reg(input logic [7:0] idx, input logic [7:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic send_sample(input logic [63:0] v, input bit allow_gap);
    if (allow_gap && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_value_bits <= v;
    start <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  function automatic logic [63:0] pick_sample();
    logic [63:0] v;
    case ($urandom_range(0, 3))
      0: v = special_vals[$urandom_range(0, 24)];
      1: v = {$urandom, $urandom};
      default: begin
        v = {$urandom, $urandom};
        v[62:52] = 11'($urandom_range(1010, 1090));
      end
    endcase
    return v;
  endfunction

  initial begin
    #2ms;
    $display("tb_double_round_and_type_convert_core: FAIL");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (special_vals[i]) send_sample(special_vals[i], 1'b1);
    drain_results();
    for (int p = 0; p < 128; p++) begin
      write_reg(REG_CONVERT_MODE, {5'($urandom_range(0, 31)), 3'(p % 8)});
      write_reg(REG_TARGET_TYPE, {4'($urandom_range(0, 15)), 4'(p / 8)});
      cfg_valid <= 1'b0;
      for (int n = 0; n < 8; n++) send_sample(pick_sample(), p < 112);
      drain_results();
    end
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_double_round_and_type_convert_core: PASS");
    end else begin
      $display("tb_double_round_and_type_convert_core: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/drtc_pkg.sv
src/drtc_op.sv
src/drtc_conv.sv
src/double_round_and_type_convert_core.sv
verif/drtc_checker.sv
verif/tb_double_round_and_type_convert_core.sv
